// ----- design/iet_pkg.sv -----
// shared types, codes and key translation tables for the input event translator
package iet_pkg;

  localparam int KEY_SLOTS_DEF = 6;

  // event types
  localparam logic [15:0] TYPE_SYNC = 16'd0;
  localparam logic [15:0] TYPE_KEY  = 16'd1;
  localparam logic [15:0] TYPE_REL  = 16'd2;
  localparam logic [15:0] TYPE_ABS  = 16'd3;

  // axis codes
  localparam logic [15:0] AXIS_X     = 16'd0;
  localparam logic [15:0] AXIS_Y     = 16'd1;
  localparam logic [15:0] AXIS_WHEEL = 16'd8;

  // button codes
  localparam logic [15:0] BTN_LEFT   = 16'h110;
  localparam logic [15:0] BTN_RIGHT  = 16'h111;
  localparam logic [15:0] BTN_MIDDLE = 16'h112;
  localparam logic [15:0] BTN_TOUCH  = 16'h14a;

  // modifier key codes
  localparam logic [15:0] KEY_LSHIFT = 16'd42;
  localparam logic [15:0] KEY_RSHIFT = 16'd54;
  localparam logic [15:0] KEY_LCTRL  = 16'd29;
  localparam logic [15:0] KEY_RCTRL  = 16'd97;
  localparam logic [15:0] KEY_LALT   = 16'd56;
  localparam logic [15:0] KEY_RALT   = 16'd100;
  localparam logic [15:0] KEY_CAPS   = 16'd58;
  localparam logic [15:0] KEY_LMETA  = 16'd125;
  localparam logic [15:0] KEY_RMETA  = 16'd126;

  // other special key codes
  localparam logic [15:0] KEY_ESC   = 16'd1;
  localparam logic [15:0] KEY_ENTER = 16'd28;
  localparam logic [15:0] KEY_BKSP  = 16'd14;
  localparam logic [15:0] KEY_TAB   = 16'd15;
  localparam logic [15:0] KEY_SPACE = 16'd57;
  localparam logic [15:0] KEY_UP    = 16'd103;
  localparam logic [15:0] KEY_DOWN  = 16'd108;
  localparam logic [15:0] KEY_LEFT  = 16'd105;
  localparam logic [15:0] KEY_RIGHT = 16'd106;
  localparam logic [15:0] KEY_DEL   = 16'd111;

  // report kinds
  localparam logic [1:0] REPORT_NONE      = 2'd0;
  localparam logic [1:0] REPORT_POINTER   = 2'd1;
  localparam logic [1:0] REPORT_KEY       = 2'd2;
  localparam logic [1:0] REPORT_MALFORMED = 2'd3;

  // register byte address
  localparam logic [2:0] ADDR_ABS_MODE = 3'd0;

  localparam logic [7:0] ROW_TOP [10] = '{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p"};
  localparam logic [7:0] ROW_MID [9]  = '{"a", "s", "d", "f", "g", "h", "j", "k", "l"};
  localparam logic [7:0] ROW_LOW [7]  = '{"z", "x", "c", "v", "b", "n", "m"};
  localparam logic [7:0] DIG_PLAIN [10] = '{"1", "2", "3", "4", "5", "6", "7", "8", "9", "0"};
  localparam logic [7:0] DIG_SHIFT [10] = '{"!", "@", "#", "$", "%", "^", "&", "*", "(", ")"};

  // request to the pressed-key list
  typedef struct packed {
    logic       en;
    logic       down;
    logic [7:0] key;
  } klist_req_t;

  // letters and digits; zero where the code is neither
  function automatic logic [8:0] ascii_code(input logic [15:0] code, input logic shift,
                                            input logic caps);
    logic [7:0] low;
    logic [7:0] sym;
    low = 8'd0;
    sym = 8'd0;
    if (code >= 16'd16 && code <= 16'd25) begin
      low = ROW_TOP[4'(code - 16'd16)];
    end else if (code >= 16'd30 && code <= 16'd38) begin
      low = ROW_MID[4'(code - 16'd30)];
    end else if (code >= 16'd44 && code <= 16'd50) begin
      low = ROW_LOW[3'(code - 16'd44)];
    end
    if (code >= 16'd2 && code <= 16'd11) begin
      sym = shift ? DIG_SHIFT[4'(code - 16'd2)] : DIG_PLAIN[4'(code - 16'd2)];
    end
    if (low != 8'd0) begin
      return {1'b0, low - ((shift || caps) ? 8'd32 : 8'd0)};
    end
    return {1'b0, sym};
  endfunction

  function automatic logic [8:0] special_code(input logic [15:0] code);
    case (code)
      KEY_ESC:              return 9'd27;
      KEY_ENTER:            return 9'd10;
      KEY_BKSP:             return 9'd8;
      KEY_TAB:              return 9'd9;
      KEY_SPACE:            return 9'd32;
      KEY_UP:               return 9'h100;
      KEY_DOWN:             return 9'h101;
      KEY_LEFT:             return 9'h102;
      KEY_RIGHT:            return 9'h103;
      KEY_DEL:              return 9'h106;
      KEY_LMETA, KEY_RMETA: return 9'h11c;
      default:              return 9'd0;
    endcase
  endfunction

endpackage

// ----- design/iet_key_list.sv -----
// pressed-key list with parallel match and swap-with-last removal
module iet_key_list #(
  parameter int KEY_SLOTS = iet_pkg::KEY_SLOTS_DEF,
  localparam int CW = $clog2(KEY_SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  iet_pkg::klist_req_t req,
  output logic [CW-1:0]       count_next
);

  logic [7:0]    keys [KEY_SLOTS];
  logic [7:0]    keys_next [KEY_SLOTS];
  logic [CW-1:0] count;
  logic [CW-1:0] hit_idx;
  logic          hit_any;
  logic [CW-1:0] last;
  logic [7:0]    last_key;
  logic          do_add;
  logic          do_remove;

  // first matching live slot
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (CW'(i) < count && keys[i] == req.key) begin
        hit_any = 1'b1;
        hit_idx = CW'(i);
      end
    end
  end

  assign last = count - CW'(1);

  always_comb begin
    last_key = 8'd0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (CW'(i) == last) begin
        last_key = keys[i];
      end
    end
  end

  assign do_add    = req.down && !hit_any && (count < CW'(KEY_SLOTS));
  assign do_remove = !req.down && hit_any && (count != '0);

  always_comb begin
    count_next = count;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keys_next[i] = keys[i];
    end
    if (do_add) begin
      count_next = count + CW'(1);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (CW'(i) == count) begin
          keys_next[i] = req.key;
        end
      end
    end else if (do_remove) begin
      count_next = last;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (CW'(i) == hit_idx) begin
          keys_next[i] = last_key;
        end
        if (CW'(i) == last) begin
          keys_next[i] = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys[i] <= 8'd0;
      end
    end else if (req.en) begin
      count <= count_next;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys[i] <= keys_next[i];
      end
    end
  end

endmodule

// ----- design/input_event_translator.sv -----
// top level of the input event translator
// Translates one input event (type, code, value) into exactly one report per transfer.
// An event is captured in an input register, decoded in one pass against the held
// pointer, button, modifier and pressed-key state, and the report is written to an
// output register in the same cycle the state is updated, so one event per clock is
// sustained while the output register drains; a report waits in the output register
// while the output side stalls. The input side keeps taking transfers while a report
// waits on the output side, until both registers are full. Sync events give a report
// of kind none. The absolute_mode register (byte address 0) selects whether pointer
// reports carry the stored absolute position or the relative deltas; write it only
// while no events are in flight.
module input_event_translator #(
  parameter int KEY_SLOTS = iet_pkg::KEY_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input events
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // ev_type[15:0], ev_code[31:16], ev_value[63:32]
  // reports
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // pos_x[31:0], pos_y[63:32], wheel_delta[79:64],
                                       // button_mask[82:80], abs_coords[83],
                                       // key_char[92:84], key_down[93],
                                       // modifier_mask[98:94], pressed_total[101:99]
  output logic [1:0]   m_axis_tuser,   // report_kind[1:0]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = $clog2(KEY_SLOTS + 1);
  localparam logic ADDR_IDX0 = iet_pkg::ADDR_ABS_MODE[2];

  // configuration register
  logic absolute_mode;

  // input register
  logic        in_valid;
  logic [15:0] in_type;
  logic [15:0] in_code;
  logic [31:0] in_value;

  // output register
  logic         out_valid;
  logic [1:0]   out_kind;
  logic [101:0] out_data;

  // held state
  logic [31:0] abs_pos_x;
  logic [31:0] abs_pos_y;
  logic [2:0]  button_state;
  logic        shift_held;
  logic        ctrl_held;
  logic        alt_held;
  logic        meta_held;
  logic        caps_on;

  logic [31:0] abs_pos_x_next;
  logic [31:0] abs_pos_y_next;
  logic [2:0]  button_state_next;
  logic        shift_held_next;
  logic        ctrl_held_next;
  logic        alt_held_next;
  logic        meta_held_next;
  logic        caps_on_next;

  // decode results
  logic        out_advance;
  logic        fire;
  logic [1:0]  kind;
  logic        is_pointer;
  logic [31:0] dx;
  logic [31:0] dy;
  logic [15:0] wheel;
  logic [8:0]  key_char;
  logic        key_listed;
  logic        down;
  logic        is_mod;
  logic [2:0]  btn_bit;
  logic [CW-1:0] count_next;
  iet_pkg::klist_req_t klist_req;

  // register access, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_IDX0) ? {31'd0, absolute_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_IDX0) begin
      absolute_mode <= pwdata[0];
    end
  end

  // handshake: the decode step moves when the output register is empty or drained
  assign out_advance   = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_advance;
  assign s_axis_tready = !in_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_type  <= s_axis_tdata[15:0];
      in_code  <= s_axis_tdata[31:16];
      in_value <= s_axis_tdata[63:32];
    end
  end

  // decode one event
  always_comb begin
    kind              = iet_pkg::REPORT_NONE;
    is_pointer        = 1'b0;
    dx                = 32'd0;
    dy                = 32'd0;
    wheel             = 16'd0;
    key_char          = 9'd0;
    key_listed        = 1'b0;
    down              = (in_value != 32'd0);
    is_mod            = 1'b0;
    btn_bit           = 3'd0;
    abs_pos_x_next    = abs_pos_x;
    abs_pos_y_next    = abs_pos_y;
    button_state_next = button_state;
    shift_held_next   = shift_held;
    ctrl_held_next    = ctrl_held;
    alt_held_next     = alt_held;
    meta_held_next    = meta_held;
    caps_on_next      = caps_on;

    case (in_type)
      iet_pkg::TYPE_SYNC: begin
        kind = iet_pkg::REPORT_NONE;
      end
      iet_pkg::TYPE_REL: begin
        case (in_code)
          iet_pkg::AXIS_X:     begin is_pointer = 1'b1; dx = in_value; end
          iet_pkg::AXIS_Y:     begin is_pointer = 1'b1; dy = in_value; end
          iet_pkg::AXIS_WHEEL: begin is_pointer = 1'b1; wheel = in_value[15:0]; end
          default:             kind = iet_pkg::REPORT_MALFORMED;
        endcase
      end
      iet_pkg::TYPE_ABS: begin
        case (in_code)
          iet_pkg::AXIS_X: begin is_pointer = 1'b1; abs_pos_x_next = in_value; end
          iet_pkg::AXIS_Y: begin is_pointer = 1'b1; abs_pos_y_next = in_value; end
          default:         kind = iet_pkg::REPORT_MALFORMED;
        endcase
      end
      iet_pkg::TYPE_KEY: begin
        case (in_code)
          iet_pkg::BTN_LEFT, iet_pkg::BTN_TOUCH: btn_bit = 3'b001;
          iet_pkg::BTN_RIGHT:                    btn_bit = 3'b010;
          iet_pkg::BTN_MIDDLE:                   btn_bit = 3'b100;
          default:                               btn_bit = 3'b000;
        endcase
        if (btn_bit != 3'd0) begin
          // button press or release
          is_pointer        = 1'b1;
          button_state_next = down ? (button_state | btn_bit) : (button_state & ~btn_bit);
        end else begin
          // modifier tracking
          case (in_code)
            iet_pkg::KEY_LSHIFT, iet_pkg::KEY_RSHIFT: begin
              shift_held_next = down;
              is_mod          = 1'b1;
            end
            iet_pkg::KEY_LCTRL, iet_pkg::KEY_RCTRL: begin
              ctrl_held_next = down;
              is_mod         = 1'b1;
            end
            iet_pkg::KEY_LALT, iet_pkg::KEY_RALT: begin
              alt_held_next = down;
              is_mod        = 1'b1;
            end
            iet_pkg::KEY_CAPS: begin
              // caps lock toggles on press only
              caps_on_next = down ? !caps_on : caps_on;
              is_mod       = 1'b1;
            end
            iet_pkg::KEY_LMETA, iet_pkg::KEY_RMETA: begin
              meta_held_next = down;
            end
            default: begin
            end
          endcase
          // modifier keys carry no ascii code, so the held state before the event serves
          key_char = iet_pkg::ascii_code(in_code, shift_held, caps_on);
          if (key_char == 9'd0) begin
            key_char = iet_pkg::special_code(in_code);
          end
          if (key_char == 9'd0 && !is_mod) begin
            kind = iet_pkg::REPORT_MALFORMED;
          end else begin
            kind       = iet_pkg::REPORT_KEY;
            key_listed = 1'b1;
          end
        end
      end
      default: begin
        kind = iet_pkg::REPORT_MALFORMED;
      end
    endcase

    if (is_pointer) begin
      kind = iet_pkg::REPORT_POINTER;
    end
  end

  // pressed-key list is touched only by a decodable key transfer
  assign klist_req.en   = fire && key_listed;
  assign klist_req.down = down;
  assign klist_req.key  = in_code[7:0];

  iet_key_list #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_key_list (
    .clk        (clk),
    .rst        (rst),
    .req        (klist_req),
    .count_next (count_next)
  );

  // state update on each decoded transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_pos_x    <= 32'd0;
      abs_pos_y    <= 32'd0;
      button_state <= 3'd0;
      shift_held   <= 1'b0;
      ctrl_held    <= 1'b0;
      alt_held     <= 1'b0;
      meta_held    <= 1'b0;
      caps_on      <= 1'b0;
    end else if (fire) begin
      abs_pos_x    <= abs_pos_x_next;
      abs_pos_y    <= abs_pos_y_next;
      button_state <= button_state_next;
      shift_held   <= shift_held_next;
      ctrl_held    <= ctrl_held_next;
      alt_held     <= alt_held_next;
      meta_held    <= meta_held_next;
      caps_on      <= caps_on_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind <= kind;
      if (kind == iet_pkg::REPORT_POINTER) begin
        // absolute mode reports the stored position after this event
        out_data <= {3'd0, 5'd0, 1'b0, 9'd0, absolute_mode, button_state_next, wheel,
                     absolute_mode ? abs_pos_y_next : dy,
                     absolute_mode ? abs_pos_x_next : dx};
      end else if (kind == iet_pkg::REPORT_KEY) begin
        out_data <= {3'(count_next),
                     meta_held_next, alt_held_next, ctrl_held_next, caps_on_next,
                     shift_held_next,
                     down, key_char, 1'b0, 3'd0, 16'd0, 32'd0, 32'd0};
      end else begin
        out_data <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

// ----- test/input_event_translator_tb.sv -----
// testbench for the input event translator: random and directed events checked against a predictor
module input_event_translator_tb;

  localparam int KEY_SLOTS   = iet_pkg::KEY_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_SHOWN   = 10;

  // first and last codes of the letter rows and the digit row
  localparam logic [15:0] KC_Q = 16'd16;
  localparam logic [15:0] KC_P = 16'd25;
  localparam logic [15:0] KC_A = 16'd30;
  localparam logic [15:0] KC_L = 16'd38;
  localparam logic [15:0] KC_Z = 16'd44;
  localparam logic [15:0] KC_M = 16'd50;
  localparam logic [15:0] KC_1 = 16'd2;
  localparam logic [15:0] KC_0 = 16'd11;

  // key rows, right-aligned: last character in the lowest byte, first in the highest used byte
  localparam logic [79:0] ROW_Q     = "qwertyuiop";
  localparam logic [79:0] ROW_A     = "asdfghjkl";
  localparam logic [79:0] ROW_Z     = "zxcvbnm";
  localparam logic [79:0] NUM_PLAIN = "1234567890";
  localparam logic [79:0] NUM_SHIFT = "!@#$%^&*()";

  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
  } event_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] wheel;
    logic [2:0]         buttons;
    logic               is_abs;
    logic [8:0]         key_char;
    logic               key_down;
    logic [4:0]         mods;
    logic [2:0]         total;
  } report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  input_event_translator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // event stream waiting to go out, and reports the block owes us
  event_t  pending_events[$];
  report_t expected_reports[$];

  // predictor copy of the block state and its register
  logic        mode_abs;
  logic [31:0] stored_x;
  logic [31:0] stored_y;
  logic [2:0]  buttons_held;
  logic        shift_on;
  logic        ctrl_on;
  logic        alt_on;
  logic        meta_on;
  logic        caps_lock;
  logic [7:0]  held_keys [KEY_SLOTS];
  int          held_count;

  // stimulus control shared with the driver and the receiver
  logic ev_taken = 1'b0;
  logic idle_on = 1'b1;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   n_queued = 0;
  int   cycles = 0;

  // bookkeeping for the summary
  int errors = 0;
  int n_results = 0;
  int n_pointer = 0;
  int n_key = 0;
  int n_malformed = 0;
  int n_sync = 0;
  int full_drops = 0;
  int n_mode_writes = 0;

  report_t got_rep;
  report_t want_rep;

  logic [15:0] special_keys [12] = '{iet_pkg::KEY_ESC, iet_pkg::KEY_ENTER, iet_pkg::KEY_BKSP,
                                     iet_pkg::KEY_TAB, iet_pkg::KEY_SPACE, iet_pkg::KEY_UP,
                                     iet_pkg::KEY_DOWN, iet_pkg::KEY_LEFT, iet_pkg::KEY_RIGHT,
                                     iet_pkg::KEY_DEL, iet_pkg::KEY_LMETA, iet_pkg::KEY_RMETA};
  logic [15:0] modifier_keys [7] = '{iet_pkg::KEY_LSHIFT, iet_pkg::KEY_RSHIFT,
                                     iet_pkg::KEY_LCTRL, iet_pkg::KEY_RCTRL,
                                     iet_pkg::KEY_LALT, iet_pkg::KEY_RALT, iet_pkg::KEY_CAPS};

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] row_char(input logic [79:0] row, input int len, input int idx);
    return row[8*(len-1-idx) +: 8];
  endfunction

  // character or special code for a key, with the current shift and caps state
  function automatic logic [8:0] char_for(input logic [15:0] code);
    logic [7:0] c;
    c = 8'd0;
    if (code >= KC_Q && code <= KC_P) begin
      c = row_char(ROW_Q, 10, code - KC_Q);
    end else if (code >= KC_A && code <= KC_L) begin
      c = row_char(ROW_A, 9, code - KC_A);
    end else if (code >= KC_Z && code <= KC_M) begin
      c = row_char(ROW_Z, 7, code - KC_Z);
    end
    // caps lock only affects letters, shift affects both
    if (c != 8'd0) return {1'b0, (shift_on || caps_lock) ? c - 8'd32 : c};
    if (code >= KC_1 && code <= KC_0) begin
      return {1'b0, row_char(shift_on ? NUM_SHIFT : NUM_PLAIN, 10, code - KC_1)};
    end
    case (code)
      iet_pkg::KEY_ESC:                       return 9'h01b;
      iet_pkg::KEY_ENTER:                     return 9'h00a;
      iet_pkg::KEY_BKSP:                      return 9'h008;
      iet_pkg::KEY_TAB:                       return 9'h009;
      iet_pkg::KEY_SPACE:                     return 9'h020;
      iet_pkg::KEY_UP:                        return 9'h100;
      iet_pkg::KEY_DOWN:                      return 9'h101;
      iet_pkg::KEY_LEFT:                      return 9'h102;
      iet_pkg::KEY_RIGHT:                     return 9'h103;
      iet_pkg::KEY_DEL:                       return 9'h106;
      iet_pkg::KEY_LMETA, iet_pkg::KEY_RMETA: return 9'h11c;
      default:                                return 9'h000;
    endcase
  endfunction

  function automatic report_t pointer_report(input logic [31:0] dx, input logic [31:0] dy,
                                             input logic [31:0] dw);
    report_t r;
    r = '0;
    r.kind    = iet_pkg::REPORT_POINTER;
    r.pos_x   = mode_abs ? stored_x : dx;
    r.pos_y   = mode_abs ? stored_y : dy;
    r.wheel   = dw[15:0];
    r.buttons = buttons_held;
    r.is_abs  = mode_abs;
    return r;
  endfunction

  function automatic report_t key_report(input logic [15:0] code, input logic [31:0] value);
    report_t    r;
    logic       down;
    logic       is_mod;
    logic [7:0] k8;
    logic [8:0] ch;
    int         hit;
    r = '0;
    down = (value != 32'd0);
    k8 = code[7:0];
    hit = -1;
    // modifiers update before translation, so shift applies to itself
    case (code)
      iet_pkg::KEY_LSHIFT, iet_pkg::KEY_RSHIFT: shift_on = down;
      iet_pkg::KEY_LCTRL, iet_pkg::KEY_RCTRL:   ctrl_on = down;
      iet_pkg::KEY_LALT, iet_pkg::KEY_RALT:     alt_on = down;
      iet_pkg::KEY_LMETA, iet_pkg::KEY_RMETA:   meta_on = down;
      iet_pkg::KEY_CAPS:                        if (down) caps_lock = !caps_lock;
      default: ;
    endcase
    is_mod = (code == iet_pkg::KEY_LSHIFT) || (code == iet_pkg::KEY_RSHIFT) ||
             (code == iet_pkg::KEY_LCTRL) || (code == iet_pkg::KEY_RCTRL) ||
             (code == iet_pkg::KEY_LALT) || (code == iet_pkg::KEY_RALT) ||
             (code == iet_pkg::KEY_CAPS);
    ch = char_for(code);
    if (ch == 9'd0 && !is_mod) begin
      r.kind = iet_pkg::REPORT_MALFORMED;
      return r;
    end
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == k8) hit = i;
    end
    if (down && hit < 0 && held_count < KEY_SLOTS) begin
      held_keys[held_count] = k8;
      held_count++;
    end else if (down && hit < 0) begin
      // list full: reported but not stored
      full_drops++;
    end else if (!down && hit >= 0) begin
      // swap the last entry into the freed slot
      held_keys[hit] = held_keys[held_count-1];
      held_keys[held_count-1] = 8'd0;
      held_count--;
    end
    r.kind     = iet_pkg::REPORT_KEY;
    r.key_char = ch;
    r.key_down = down;
    r.mods     = {meta_on, alt_on, ctrl_on, caps_lock, shift_on};
    r.total    = 3'(held_count);
    return r;
  endfunction

  // expected report for one event, updating the predicted state
  function automatic report_t translate_event(input event_t ev);
    report_t    r;
    logic [2:0] bit_sel;
    r = '0;
    bit_sel = 3'b000;
    case (ev.ev_type)
      iet_pkg::TYPE_SYNC: r.kind = iet_pkg::REPORT_NONE;
      iet_pkg::TYPE_REL: begin
        case (ev.ev_code)
          iet_pkg::AXIS_X:     r = pointer_report(ev.ev_value, 32'd0, 32'd0);
          iet_pkg::AXIS_Y:     r = pointer_report(32'd0, ev.ev_value, 32'd0);
          iet_pkg::AXIS_WHEEL: r = pointer_report(32'd0, 32'd0, ev.ev_value);
          default:             r.kind = iet_pkg::REPORT_MALFORMED;
        endcase
      end
      iet_pkg::TYPE_ABS: begin
        case (ev.ev_code)
          iet_pkg::AXIS_X: begin
            stored_x = ev.ev_value;
            r = pointer_report(32'd0, 32'd0, 32'd0);
          end
          iet_pkg::AXIS_Y: begin
            stored_y = ev.ev_value;
            r = pointer_report(32'd0, 32'd0, 32'd0);
          end
          default: r.kind = iet_pkg::REPORT_MALFORMED;
        endcase
      end
      iet_pkg::TYPE_KEY: begin
        case (ev.ev_code)
          iet_pkg::BTN_LEFT, iet_pkg::BTN_TOUCH: bit_sel = 3'b001;
          iet_pkg::BTN_RIGHT:                    bit_sel = 3'b010;
          iet_pkg::BTN_MIDDLE:                   bit_sel = 3'b100;
          default:                               bit_sel = 3'b000;
        endcase
        if (bit_sel != 3'b000) begin
          if (ev.ev_value != 32'd0) buttons_held = buttons_held | bit_sel;
          else buttons_held = buttons_held & ~bit_sel;
          r = pointer_report(32'd0, 32'd0, 32'd0);
        end else begin
          r = key_report(ev.ev_code, ev.ev_value);
        end
      end
      default: r.kind = iet_pkg::REPORT_MALFORMED;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[input_event_translator] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side: offer events on the falling edge, note transfers on the rising edge
  // ---------------------------------------------------------------------------

  // each transfer gets its expected report right away, with the register as it stands
  always @(posedge clk) begin
    ev_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_reports.push_back(translate_event(pending_events[0]));
      void'(pending_events.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !ev_taken) begin
      // offer still open, hold valid and data
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_events.size() > 0) begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        // idle burst, starting with this one
        send_gap = $urandom_range(0, 7);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_events[0].ev_value, pending_events[0].ev_code,
                          pending_events[0].ev_type};
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random stalls and one long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      // long hold-off so the block fills and pushes back on the input
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
               n_results, what, want, got);
    end
  endtask

  task automatic check_report(input report_t want, input report_t got);
    if (got.kind !== want.kind)
      note_mismatch("report_kind", 32'(want.kind), 32'(got.kind));
    if (got.pos_x !== want.pos_x)
      note_mismatch("pos_x", 32'(want.pos_x), 32'(got.pos_x));
    if (got.pos_y !== want.pos_y)
      note_mismatch("pos_y", 32'(want.pos_y), 32'(got.pos_y));
    if (got.wheel !== want.wheel)
      note_mismatch("wheel_delta", 32'(want.wheel), 32'(got.wheel));
    if (got.buttons !== want.buttons)
      note_mismatch("button_mask", 32'(want.buttons), 32'(got.buttons));
    if (got.is_abs !== want.is_abs)
      note_mismatch("abs_coords", 32'(want.is_abs), 32'(got.is_abs));
    if (got.key_char !== want.key_char)
      note_mismatch("key_char", 32'(want.key_char), 32'(got.key_char));
    if (got.key_down !== want.key_down)
      note_mismatch("key_down", 32'(want.key_down), 32'(got.key_down));
    if (got.mods !== want.mods)
      note_mismatch("modifier_mask", 32'(want.mods), 32'(got.mods));
    if (got.total !== want.total)
      note_mismatch("pressed_total", 32'(want.total), 32'(got.total));
  endtask

  // every report transfer is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got_rep.kind     = m_axis_tuser;
      got_rep.pos_x    = m_axis_tdata[31:0];
      got_rep.pos_y    = m_axis_tdata[63:32];
      got_rep.wheel    = m_axis_tdata[79:64];
      got_rep.buttons  = m_axis_tdata[82:80];
      got_rep.is_abs   = m_axis_tdata[83];
      got_rep.key_char = m_axis_tdata[92:84];
      got_rep.key_down = m_axis_tdata[93];
      got_rep.mods     = m_axis_tdata[98:94];
      got_rep.total    = m_axis_tdata[101:99];
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("unexpected report %0d: kind %0d data 0x%0h",
                   n_results, m_axis_tuser, m_axis_tdata);
        end
      end else begin
        want_rep = expected_reports.pop_front();
        check_report(want_rep, got_rep);
        case (want_rep.kind)
          iet_pkg::REPORT_POINTER:   n_pointer++;
          iet_pkg::REPORT_KEY:       n_key++;
          iet_pkg::REPORT_MALFORMED: n_malformed++;
          default:                   n_sync++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_event(input logic [15:0] t, input logic [15:0] c, input logic [31:0] v);
    event_t ev;
    ev.ev_type = t;
    ev.ev_code = c;
    ev.ev_value = v;
    pending_events.push_back(ev);
    n_queued++;
  endtask

  // values weighted toward the edges of the 32-bit range
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hffff_ffff;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5:       return 32'($urandom_range(0, 255)) - 32'd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return 16'(KC_Q + $urandom_range(0, 9));
      1:       return 16'(KC_A + $urandom_range(0, 8));
      2:       return 16'(KC_Z + $urandom_range(0, 6));
      3:       return 16'(KC_1 + $urandom_range(0, 9));
      4:       return special_keys[$urandom_range(0, 11)];
      default: return modifier_keys[$urandom_range(0, 6)];
    endcase
  endfunction

  // press a handful of keys, then release them in random order
  task automatic typing_burst();
    logic [15:0] down_keys[$];
    logic [15:0] k;
    logic [31:0] v;
    int          n;
    int          idx;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      // sometimes press a key already down
      if (down_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
        k = down_keys[$urandom_range(0, down_keys.size() - 1)];
      end else begin
        k = pick_key();
      end
      v = rand_value();
      if (v == 32'd0) v = 32'd1;
      push_event(iet_pkg::TYPE_KEY, k, v);
      down_keys.push_back(k);
      if ($urandom_range(0, 5) == 0) push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_X, rand_value());
    end
    // release of a random key, often one that is not in the list
    if ($urandom_range(0, 3) == 0) push_event(iet_pkg::TYPE_KEY, pick_key(), 32'd0);
    while (down_keys.size() > 0) begin
      idx = $urandom_range(0, down_keys.size() - 1);
      push_event(iet_pkg::TYPE_KEY, down_keys[idx], 32'd0);
      down_keys.delete(idx);
    end
  endtask

  task automatic fill_random(input int goal);
    int          sel;
    logic [15:0] t;
    while (n_queued < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
        case ($urandom_range(0, 2))
          0:       push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_X, rand_value());
          1:       push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_Y, rand_value());
          default: push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_WHEEL, rand_value());
        endcase
      end else if (sel < 24) begin
        push_event(iet_pkg::TYPE_ABS, $urandom_range(0, 1) ? iet_pkg::AXIS_X : iet_pkg::AXIS_Y,
                   rand_value());
      end else if (sel < 34) begin
        case ($urandom_range(0, 3))
          0:       push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_LEFT,
                              $urandom_range(0, 1) ? rand_value() : 32'd0);
          1:       push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_RIGHT,
                              $urandom_range(0, 1) ? rand_value() : 32'd0);
          2:       push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_MIDDLE,
                              $urandom_range(0, 1) ? rand_value() : 32'd0);
          default: push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_TOUCH,
                              $urandom_range(0, 1) ? rand_value() : 32'd0);
        endcase
      end else if (sel < 70) begin
        typing_burst();
      end else if (sel < 80) begin
        push_event(iet_pkg::TYPE_KEY, pick_key(), $urandom_range(0, 1) ? rand_value() : 32'd0);
      end else if (sel < 85) begin
        push_event(iet_pkg::TYPE_SYNC, 16'($urandom), rand_value());
      end else begin
        // noise: odd types, unknown axes and key codes, raw random fields
        t = $urandom_range(0, 1) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        if ($urandom_range(0, 1)) push_event(t, 16'($urandom_range(0, 300)), $urandom);
        else push_event(t, 16'($urandom), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_reports.size() != 0) @(posedge clk);
  endtask

  // register write over the config port, then read it back
  task automatic set_abs_mode(input logic v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= iet_pkg::ADDR_ABS_MODE;
    pwdata  <= {31'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_abs = v;
    n_mode_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, v}) note_mismatch("absolute_mode readback", {31'd0, v}, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    mode_abs = 1'b0;
    stored_x = '0;
    stored_y = '0;
    buttons_held = '0;
    shift_on = 1'b0;
    ctrl_on = 1'b0;
    alt_on = 1'b0;
    meta_on = 1'b0;
    caps_lock = 1'b0;
    held_count = 0;
    for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = 8'd0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every event kind, the corner cases
    set_abs_mode(1'b0);
    push_event(iet_pkg::TYPE_SYNC, 16'd0, 32'd0);
    push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_X, 32'h7fff_ffff);
    push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_Y, 32'h8000_0000);
    push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_WHEEL, 32'hffff_8000);
    push_event(iet_pkg::TYPE_REL, iet_pkg::AXIS_WHEEL, 32'h0001_7fff);
    push_event(iet_pkg::TYPE_REL, 16'hffff, 32'd5);
    push_event(iet_pkg::TYPE_ABS, iet_pkg::AXIS_X, 32'hffff_ffff);
    push_event(iet_pkg::TYPE_ABS, iet_pkg::AXIS_Y, 32'h8000_0000);
    push_event(iet_pkg::TYPE_ABS, 16'd2, 32'd7);
    push_event(16'hffff, 16'hffff, 32'hffff_ffff);
    push_event(16'd4, 16'd0, 32'd0);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_LEFT, 32'd1);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_TOUCH, 32'h8000_0000);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_RIGHT, 32'd1);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_MIDDLE, 32'd1);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::BTN_LEFT, 32'd0);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_LSHIFT, 32'd1);
    push_event(iet_pkg::TYPE_KEY, KC_A, 32'd1);
    push_event(iet_pkg::TYPE_KEY, KC_1, 32'd2);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_LSHIFT, 32'd0);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_CAPS, 32'd1);
    push_event(iet_pkg::TYPE_KEY, KC_A, 32'd0);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_CAPS, 32'd0);
    push_event(iet_pkg::TYPE_KEY, 16'hffff, 32'd1);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_LCTRL, 32'd1);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_RALT, 32'hffff_ffff);
    push_event(iet_pkg::TYPE_KEY, iet_pkg::KEY_LMETA, 32'd1);
    wait_drained();

    // random phases, switching the pointer mode between them
    set_abs_mode(1'b1);
    fill_random(165);
    wait_drained();

    // long output hold-off while the input keeps coming
    set_abs_mode(1'b0);
    hold_req = hold_req + 1;
    fill_random(305);
    wait_drained();

    // a stretch with no idling on either side
    set_abs_mode(1'b1);
    idle_on = 1'b0;
    fill_random(445);
    wait_drained();

    set_abs_mode(1'b0);
    idle_on = 1'b1;
    fill_random(585);
    wait_drained();

    set_abs_mode(1'b1);
    fill_random(725);
    wait_drained();

    // closing phase at full rate
    set_abs_mode(1'b0);
    idle_on = 1'b0;
    fill_random(850);
    wait_drained();

    // let any stray report show up before closing
    repeat (10) @(posedge clk);

    $display("covered %0d events: %0d pointer, %0d key, %0d malformed, %0d empty reports",
             n_queued, n_pointer, n_key, n_malformed, n_sync);
    $display("%0d mode writes, %0d presses dropped on a full key list, one %0d-cycle hold",
             n_mode_writes, full_drops, HOLD_CYCLES);
    if (errors == 0) begin
      $display("[input_event_translator] OK");
    end else begin
      $display("[input_event_translator] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/iet_pkg.sv
design/iet_key_list.sv
design/input_event_translator.sv
test/input_event_translator_tb.sv
